// File: hdl/life_generation_engine_macros.svh
// Assertion macros shared by the life generation engine RTL.
`ifndef LIFE_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ENGINE_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define LGE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define LGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lge_pkg.sv
// Types and constants shared by the life generation engine modules.
package lge_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 64;
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

  typedef logic [GRID_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef struct packed {
    row_t above;
    row_t cur;
    row_t below;
  } row_set_t;

endpackage

// File: hdl/life_generation_engine.sv
// Top level of the life generation engine: cell grid, sequencer and result register.
//
//   Channel | Ports                                                | Direction
//   in      | in_valid, in_ready, in_action, in_row_index,        | request in
//           | in_col_index, in_cell_value                          |
//   out     | out_valid, out_ready, out_read_alive, out_action_done| request out
//
// A cell write or read runs through row read, update or select, and result, in that order.
// A generation runs through first row read, priming, one row a cycle through the row unit,
// and result, limited by the single read and write port of the RAM.
// Reset clears the per-row valid bits; a row not yet written reads as dead.
// A finished result waits in the output register while the sequencer returns to idle.
module life_generation_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [lge_pkg::ROW_W-1:0] in_row_index,
  input  logic [lge_pkg::COL_W-1:0] in_col_index,
  input  logic                      in_cell_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_read_alive,
  output logic                      out_action_done
);
  import lge_pkg::*;

  `include "life_generation_engine_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CELL  = 5'b00010,
    ST_PRIME = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   sweep_row_r, sweep_row_nxt;
  row_t               above_r, above_nxt;
  row_t               cur_r, cur_nxt;
  act_t               act_r, act_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               val_r, val_nxt;
  logic               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_alive_r, out_alive_nxt;
  logic [GRID_ROWS-1:0] valid_r, valid_nxt;
  logic [ROW_W-1:0]   rd_addr_q_r, rd_addr_q_nxt;

  logic             rd_en, wr_en;
  logic [ROW_W-1:0] rd_addr, wr_addr;
  row_t             wr_data, rd_data, rd_row, mod_row, next_row;
  row_set_t         rows;
  logic             row_ok, col_ok, accept, q_ok;

  lge_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lge_row_unit u_row (
    .rows     (rows),
    .next_row (next_row)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_read_alive  = out_alive_r;
  assign out_action_done = 1'b1;

  assign row_ok = {1'b0, in_row_index} < (ROW_W + 1)'(GRID_ROWS);
  assign col_ok = {1'b0, in_col_index} < (COL_W + 1)'(GRID_COLS);
  assign q_ok   = {1'b0, rd_addr_q_r} < (ROW_W + 1)'(GRID_ROWS);
  assign rd_row = (q_ok && valid_r[rd_addr_q_r]) ? rd_data : '0;

  assign rows.above = above_r;
  assign rows.cur   = cur_r;
  assign rows.below = (sweep_row_r == LAST_ROW) ? '0 : rd_row;

  always_comb begin
    mod_row        = rd_row;
    mod_row[col_r] = val_r;
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_row_nxt = sweep_row_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    act_nxt       = act_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    valid_nxt     = valid_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_alive_nxt = out_alive_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt = act_t'(in_action);
          row_nxt = in_row_index;
          col_nxt = in_col_index;
          val_nxt = in_cell_value;
          res_nxt = 1'b0;
          case (act_t'(in_action))
            ACT_WRITE, ACT_READ: begin
              if (row_ok && col_ok) begin
                rd_en     = 1'b1;
                rd_addr   = in_row_index;
                state_nxt = ST_CELL;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            ACT_STEP: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ST_PRIME;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_CELL: begin
        if (act_r == ACT_WRITE) begin
          wr_en              = 1'b1;
          wr_addr            = row_r;
          wr_data            = mod_row;
          valid_nxt[row_r]   = 1'b1;
        end else begin
          res_nxt = rd_row[col_r];
        end
        state_nxt = ST_FIN;
      end
      ST_PRIME: begin
        cur_nxt       = rd_row;
        above_nxt     = '0;
        sweep_row_nxt = '0;
        rd_en         = 1'b1;
        rd_addr       = ROW_W'(1);
        state_nxt     = ST_SWEEP;
      end
      ST_SWEEP: begin
        wr_en                  = 1'b1;
        wr_addr                = sweep_row_r;
        wr_data                = next_row;
        valid_nxt[sweep_row_r] = 1'b1;
        above_nxt              = cur_r;
        cur_nxt                = rows.below;
        rd_en                  = 1'b1;
        rd_addr                = ROW_W'(sweep_row_r + ROW_W'(2));
        if (sweep_row_r == LAST_ROW) begin
          sweep_row_nxt = '0;
          state_nxt     = ST_FIN;
        end else begin
          sweep_row_nxt = sweep_row_r + ROW_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rd_addr_q_nxt = rd_en ? rd_addr : rd_addr_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sweep_row_r <= '0;
      above_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_row_r <= sweep_row_nxt;
      above_r     <= above_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    act_r       <= act_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    val_r       <= val_nxt;
    res_r       <= res_nxt;
    out_alive_r <= out_alive_nxt;
    rd_addr_q_r <= rd_addr_q_nxt;
  end

  `LGE_ASSERT_NEXT(a_step_primes, accept && (in_action == ACT_STEP), state_r == ST_PRIME, "advance request did not start a sweep")
  `LGE_ASSERT_NEXT(a_sweep_ends, (state_r == ST_SWEEP) && (sweep_row_r == LAST_ROW), (state_r == ST_FIN) && (sweep_row_r == '0), "sweep did not end after the last row")
  `LGE_ASSERT_SAME(a_fin_row_zero, state_r == ST_FIN, sweep_row_r == '0, "sweep row not cleared after a request")
  `LGE_ASSERT_NEXT(a_fin_delivers, (state_r == ST_FIN) && !out_valid_r, out_valid_r && (state_r == ST_IDLE), "finished request not moved to the output")

endmodule

// File: hdl/lge_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lge_row_unit.sv
// Column-parallel neighbor count and B3/S23 rule for one grid row.
module lge_row_unit (
  input  lge_pkg::row_set_t rows,
  output lge_pkg::row_t     next_row
);
  import lge_pkg::*;

  row_t above_l, above_r, cur_l, cur_r, below_l, below_r;
  logic [3:0] cnt [GRID_COLS];

  assign above_l = rows.above << 1;
  assign above_r = rows.above >> 1;
  assign cur_l   = rows.cur << 1;
  assign cur_r   = rows.cur >> 1;
  assign below_l = rows.below << 1;
  assign below_r = rows.below >> 1;

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      cnt[c] = 4'(above_l[c]) + 4'(rows.above[c]) + 4'(above_r[c]) +
               4'(cur_l[c]) + 4'(cur_r[c]) +
               4'(below_l[c]) + 4'(rows.below[c]) + 4'(below_r[c]);
      next_row[c] = (cnt[c] == 4'd3) || (rows.cur[c] && (cnt[c] == 4'd2));
    end
  end

endmodule
